// ===== src/scc_pkg.sv =====
// ----------------------------------------------------------------------------
// scc_pkg
// Types, constants and the month table shared by the seconds/calendar
// converter.
// ----------------------------------------------------------------------------
package scc_pkg;

  typedef enum logic {
    OP_SPLIT = 1'b0,
    OP_BUILD = 1'b1
  } scc_op_t;

  typedef struct packed {
    scc_op_t     opcode;
    logic [31:0] seconds_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  sec_in;
  } scc_in_t;

  typedef struct packed {
    logic [24:0] seconds_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  sec_out;
    logic        beyond_year;
  } scc_out_t;

  // Stage 0 is the input register, the last stage is the result register.
  localparam int NUM_STAGES = 5;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } scc_ctrl_t;

  // x / 60 == (x * DIV60_MAGIC) >> DIV60_SHIFT for every 32-bit x.
  localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
  localparam int          DIV60_SHIFT = 37;
  // x / 3 == (x * DIV3_MAGIC) >> DIV3_SHIFT for every x below 2^19.
  localparam logic [17:0] DIV3_MAGIC  = 18'd174763;
  localparam int          DIV3_SHIFT  = 19;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [4:0]  HOURS_PER_DAY = 5'd24;
  localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
  localparam logic [3:0]  LAST_MONTH    = 4'd11;

  // Days in the year before the first day of the given month.
  function automatic logic [8:0] cum_days(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== src/scc_in_if.sv =====
// ----------------------------------------------------------------------------
// scc_in_if
// Valid/ready channel carrying one conversion request item.
// ----------------------------------------------------------------------------
interface scc_in_if;
  import scc_pkg::*;

  logic    valid;
  logic    ready;
  scc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/scc_out_if.sv =====
// ----------------------------------------------------------------------------
// scc_out_if
// Valid/ready channel carrying one conversion result item.
// ----------------------------------------------------------------------------
interface scc_out_if;
  import scc_pkg::*;

  logic     valid;
  logic     ready;
  scc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/scc_ctrl.sv =====
// ----------------------------------------------------------------------------
// scc_ctrl
// Valid bits and per-stage load enables of the converter pipeline.
// ----------------------------------------------------------------------------
module scc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output scc_pkg::scc_ctrl_t ctrl
);
  import scc_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] ready;

  // A stage may load when it is empty or when its item moves on this cycle.
  always_comb begin
    ready[NUM_STAGES-1] = !valid[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) begin
        valid[0] <= in_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ready[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign ctrl.load = ready;
  assign in_ready  = ready[0];
  assign out_valid = valid[NUM_STAGES-1];

endmodule

// ===== src/scc_split.sv =====
// ----------------------------------------------------------------------------
// scc_split
// Breaks a seconds count into whole days, the low five bits of the hour count,
// minutes and seconds with reciprocal multiplies, one multiply per stage.
// ----------------------------------------------------------------------------
module scc_split (
  input  logic               clk,
  input  scc_pkg::scc_ctrl_t ctrl,
  input  logic [31:0]        seconds,
  output logic [15:0]        days,
  output logic [4:0]         hours_lo,
  output logic [5:0]         minute,
  output logic [5:0]         sec
);
  import scc_pkg::*;

  logic [63:0] prod1;
  logic [57:0] prod2;
  logic [34:0] prod3;

  // Stage 1
  logic [26:0] q1;
  logic [5:0]  s_lo;
  // Stage 2
  logic [20:0] q2;
  logic [5:0]  q1_lo;
  logic [5:0]  sec2;

  // Only the low six bits of a remainder below 60 are needed, so the
  // back-multiplication is done modulo 64.
  assign prod1 = 64'(seconds) * 64'(DIV60_MAGIC);
  assign prod2 = 58'(q1) * 58'(DIV60_MAGIC);
  assign prod3 = 35'(q2[20:3]) * 35'(DIV3_MAGIC);

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      q1   <= prod1[DIV60_SHIFT+26:DIV60_SHIFT];
      s_lo <= seconds[5:0];
    end
    if (ctrl.load[2]) begin
      q2    <= prod2[DIV60_SHIFT+20:DIV60_SHIFT];
      q1_lo <= q1[5:0];
      sec2  <= s_lo - 6'(q1[5:0] * SECS_PER_MIN);
    end
    if (ctrl.load[3]) begin
      // Dividing by 24 is a shift by three and a divide by three.
      days     <= prod3[DIV3_SHIFT+15:DIV3_SHIFT];
      hours_lo <= q2[4:0];
      minute   <= q1_lo - 6'(q2[5:0] * SECS_PER_MIN);
      sec      <= sec2;
    end
  end

endmodule

// ===== src/scc_rebuild.sv =====
// ----------------------------------------------------------------------------
// scc_rebuild
// Rebuilds a seconds count from month, day, hour, minute and second.
// ----------------------------------------------------------------------------
module scc_rebuild (
  input  logic               clk,
  input  scc_pkg::scc_ctrl_t ctrl,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic [4:0]         hour,
  input  logic [5:0]         minute,
  input  logic [5:0]         sec,
  output logic [24:0]        total
);
  import scc_pkg::*;

  logic [3:0]  month_sat;
  logic [4:0]  day_adj;
  logic [8:0]  day_count_next;
  logic [16:0] tod_next;

  logic [8:0]  day_count;
  logic [16:0] tod;
  logic [24:0] total2;

  // Months past December count as December, and day zero counts as day one.
  always_comb begin
    month_sat      = (month > LAST_MONTH) ? LAST_MONTH : month;
    day_adj        = (day == 5'd0) ? 5'd1 : day;
    day_count_next = cum_days(month_sat) + 9'(day_adj) - 9'd1;
    tod_next       = 17'(hour) * 17'(SECS_PER_HOUR) + 17'(minute) * 17'(SECS_PER_MIN)
                   + 17'(sec);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      day_count <= day_count_next;
      tod       <= tod_next;
    end
    if (ctrl.load[2]) begin
      total2 <= 25'(day_count) * 25'(SECS_PER_DAY) + 25'(tod);
    end
    if (ctrl.load[3]) begin
      total <= total2;
    end
  end

endmodule

// ===== src/scc_calendar.sv =====
// ----------------------------------------------------------------------------
// scc_calendar
// Turns a day count into month and day of month, and finishes the hour.
// ----------------------------------------------------------------------------
module scc_calendar (
  input  logic [15:0] days,
  input  logic [4:0]  hours_lo,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hour,
  output logic        beyond_year
);
  import scc_pkg::*;

  logic [3:0] m;
  logic [8:0] day_of_year;

  always_comb begin
    m = 4'd0;
    for (int k = 1; k <= 11; k++) begin
      if (days >= 16'(cum_days(4'(k)))) begin
        m = 4'(k);
      end
    end
    beyond_year = (days >= 16'(DAYS_PER_YEAR));
    day_of_year = days[8:0] - cum_days(m) + 9'd1;
    month       = beyond_year ? 4'd0 : m;
    day         = beyond_year ? 5'd0 : day_of_year[4:0];
    // The remainder is below 24, so five bits of the back-product suffice.
    hour        = hours_lo - 5'(days[4:0] * HOURS_PER_DAY);
  end

endmodule

// ===== src/seconds_calendar_converter.sv =====
// ----------------------------------------------------------------------------
// seconds_calendar_converter
// Converts a seconds count into month, day, hour, minute and second of a
// non-leap year, or rebuilds the seconds count from those fields.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Contents
//   -------   ---   ---------------------------------------------------
//   request   in    opcode, seconds_in, month_in, day_in, hour_in,
//                   minute_in, sec_in
//   result    out   seconds_out, month_out, day_out, hour_out,
//                   minute_out, sec_out, beyond_year
//
// One item can be accepted in every cycle. A result passes through the input
// register, three stages with one reciprocal multiply each, and the result
// register before it is offered on the result channel. Reset clears only the
// stage valid bits. A stalled result holds its stage, earlier stages keep
// filling, and the request channel stalls once all five stages are full.
module seconds_calendar_converter (
  input  logic clk,
  input  logic rst,
  scc_in_if.sink    request,
  scc_out_if.source result
);
  import scc_pkg::*;

  scc_ctrl_t   ctrl;
  scc_in_t     in_reg;
  scc_op_t     op1;
  scc_op_t     op2;
  scc_op_t     op3;
  scc_out_t    out_reg;
  scc_out_t    out_next;

  logic [15:0] days;
  logic [4:0]  hours_lo;
  logic [5:0]  minute;
  logic [5:0]  sec;
  logic [24:0] total;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [4:0]  cal_hour;
  logic        cal_beyond;

  scc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .ctrl      (ctrl)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      in_reg <= request.data;
    end
    if (ctrl.load[1]) begin
      op1 <= in_reg.opcode;
    end
    if (ctrl.load[2]) begin
      op2 <= op1;
    end
    if (ctrl.load[3]) begin
      op3 <= op2;
    end
    if (ctrl.load[NUM_STAGES-1]) begin
      out_reg <= out_next;
    end
  end

  scc_split u_split (
    .clk      (clk),
    .ctrl     (ctrl),
    .seconds  (in_reg.seconds_in),
    .days     (days),
    .hours_lo (hours_lo),
    .minute   (minute),
    .sec      (sec)
  );

  scc_rebuild u_rebuild (
    .clk    (clk),
    .ctrl   (ctrl),
    .month  (in_reg.month_in),
    .day    (in_reg.day_in),
    .hour   (in_reg.hour_in),
    .minute (in_reg.minute_in),
    .sec    (in_reg.sec_in),
    .total  (total)
  );

  scc_calendar u_calendar (
    .days        (days),
    .hours_lo    (hours_lo),
    .month       (cal_month),
    .day         (cal_day),
    .hour        (cal_hour),
    .beyond_year (cal_beyond)
  );

  always_comb begin
    out_next = '0;
    if (op3 == OP_BUILD) begin
      out_next.seconds_out = total;
    end else begin
      out_next.month_out   = cal_month;
      out_next.day_out     = cal_day;
      out_next.hour_out    = cal_hour;
      out_next.minute_out  = minute;
      out_next.sec_out     = sec;
      out_next.beyond_year = cal_beyond;
    end
  end

  assign result.data = out_reg;

`ifndef SYNTH
  a_build_clears_time: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.seconds_out != 25'd0 |->
      result.data.hour_out == 5'd0 && result.data.minute_out == 6'd0 &&
      result.data.sec_out == 6'd0 && !result.data.beyond_year)
    else $error("rebuilt seconds item carries time-of-day fields");

  a_beyond_clears_date: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.beyond_year |->
      result.data.month_out == 4'd0 && result.data.day_out == 5'd0)
    else $error("item beyond one year carries a date");

  a_time_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |->
      result.data.hour_out < HOURS_PER_DAY && result.data.minute_out < SECS_PER_MIN &&
      result.data.sec_out < SECS_PER_MIN)
    else $error("time field out of range");

  a_day_zero_month_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.day_out == 5'd0 |-> result.data.month_out == 4'd0)
    else $error("month set without a day of month");

  a_full_pipe_stalls: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready && (&ctrl.load) |-> 1'b0)
    else $error("stalled result stage still loading");
`endif

endmodule
